/* hw/rtl/decaying_tone_generator_defines.svh */
// ----------------------------------------------------------------------------
// Decaying tone generator assertion macros
// Concurrent assertion helpers; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef DECAYING_TONE_GENERATOR_DEFINES_SVH
`define DECAYING_TONE_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define DTG_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication
`define DTG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define DTG_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define DTG_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* hw/rtl/dtg_pkg.sv */
// ----------------------------------------------------------------------------
// Decaying tone generator package
// Shared types, codes and note/length tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtg_pkg;

   // Defaults and limits
   localparam int DEFAULT_NOTE_COUNT = 13;
   localparam int TABLE_NOTES        = 13;
   localparam int NOTE_W             = 4;
   localparam int LENGTH_W           = 5;
   localparam int OPCODE_W           = 2;
   localparam int CSR_INDEX_W        = 2;
   localparam int CSR_DATA_W         = 16;

   // Opcodes
   localparam logic [OPCODE_W-1:0] OP_TICK = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_NOTE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_REST = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_DECAY_INTERVAL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SLOW_DECAY     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MEDIUM_DECAY   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FAST_DECAY     = 2'd3;

   // Register reset values
   localparam logic [15:0] RESET_DECAY_INTERVAL = 16'd50000;
   localparam logic [7:0]  RESET_SLOW_DECAY     = 8'd5;
   localparam logic [7:0]  RESET_MEDIUM_DECAY   = 8'd7;
   localparam logic [7:0]  RESET_FAST_DECAY     = 8'd10;

   localparam logic [7:0] FULL_VOLUME = 8'd255;

   typedef struct packed {
      logic [15:0] decay_interval;
      logic [7:0]  slow_decay;
      logic [7:0]  medium_decay;
      logic [7:0]  fast_decay;
   } cfg_type;

   typedef struct packed {
      logic [7:0] pwm_level;
      logic [2:0] led_pattern;
      logic       busy_res;
      logic       rejected;
   } result_type;

   // Half period in ticks per note
   function automatic logic [10:0] half_ticks(input logic [NOTE_W-1:0] idx);
      logic [10:0] v;
      case (idx)
         4'd1:    v = 11'd1132;
         4'd2:    v = 11'd1012;
         4'd3:    v = 11'd950;
         4'd4:    v = 11'd851;
         4'd5:    v = 11'd758;
         4'd6:    v = 11'd715;
         4'd7:    v = 11'd633;
         4'd8:    v = 11'd568;
         4'd9:    v = 11'd506;
         4'd10:   v = 11'd473;
         4'd11:   v = 11'd422;
         4'd12:   v = 11'd379;
         default: v = 11'd1270;
      endcase
      return v;
   endfunction

   // Periods in a whole note per note
   function automatic logic [11:0] whole_periods(input logic [NOTE_W-1:0] idx);
      logic [11:0] v;
      case (idx)
         4'd1:    v = 12'd880;
         4'd2:    v = 12'd976;
         4'd3:    v = 12'd1040;
         4'd4:    v = 12'd1168;
         4'd5:    v = 12'd1312;
         4'd6:    v = 12'd1392;
         4'd7:    v = 12'd1568;
         4'd8:    v = 12'd1760;
         4'd9:    v = 12'd1968;
         4'd10:   v = 12'd2080;
         4'd11:   v = 12'd2336;
         4'd12:   v = 12'd2624;
         default: v = 12'd784;
      endcase
      return v;
   endfunction

   // LED bits per note
   function automatic logic [2:0] led_bits(input logic [NOTE_W-1:0] idx);
      logic [2:0] v;
      case (idx)
         4'd1, 4'd8:  v = 3'd5;
         4'd2, 4'd9:  v = 3'd7;
         4'd3, 4'd10: v = 3'd1;
         4'd4, 4'd11: v = 3'd2;
         4'd5, 4'd12: v = 3'd4;
         4'd6:        v = 3'd3;
         default:     v = 3'd6;
      endcase
      return v;
   endfunction

   // Sixteenths of a whole note per length code; 0 marks an invalid code
   function automatic logic [4:0] length_mult(input logic [LENGTH_W-1:0] code);
      logic [4:0] v;
      case (code)
         5'd1:    v = 5'd16;
         5'd2:    v = 5'd8;
         5'd3:    v = 5'd6;
         5'd4:    v = 5'd4;
         5'd6:    v = 5'd3;
         5'd8:    v = 5'd2;
         5'd16:   v = 5'd1;
         default: v = 5'd0;
      endcase
      return v;
   endfunction

   // Rest length in ticks per length code (125000 ticks per sixteenth)
   function automatic logic [20:0] rest_ticks(input logic [LENGTH_W-1:0] code);
      logic [20:0] v;
      case (code)
         5'd1:    v = 21'd2000000;
         5'd2:    v = 21'd1000000;
         5'd3:    v = 21'd750000;
         5'd4:    v = 21'd500000;
         5'd6:    v = 21'd375000;
         5'd8:    v = 21'd250000;
         5'd16:   v = 21'd125000;
         default: v = 21'd0;
      endcase
      return v;
   endfunction

endpackage

/* hw/rtl/dtg_engine.sv */
// ----------------------------------------------------------------------------
// Decaying tone generator play engine
// Holds the playback state, applies one item per advance and presents the
// result that follows from the updated state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtg_engine #(
   parameter int NOTE_COUNT = dtg_pkg::DEFAULT_NOTE_COUNT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [dtg_pkg::OPCODE_W-1:0]  opcode,
   input  logic [dtg_pkg::NOTE_W-1:0]    note_index,
   input  logic [dtg_pkg::LENGTH_W-1:0]  note_length,
   input  dtg_pkg::cfg_type              cfg,
   output dtg_pkg::result_type           result
);

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_NOTE,
      MODE_REST
   } mode_type;

   localparam logic [4:0] NoteLimit  = 5'(NOTE_COUNT);
   localparam logic [4:0] TableLimit = 5'(dtg_pkg::TABLE_NOTES);

   mode_type    mode_ff, mode_in;
   logic [7:0]  volume_ff, volume_in;
   logic [7:0]  step_ff, step_in;
   logic [10:0] half_count_ff, half_count_in;
   logic [11:0] periods_ff, periods_in;
   logic        phase_ff, phase_in;
   logic [15:0] decay_count_ff, decay_count_in;
   logic [20:0] rest_left_ff, rest_left_in;
   logic [3:0]  note_ff, note_in;

   logic [3:0]  table_idx;
   logic [3:0]  out_idx;
   logic [15:0] interval;
   logic [15:0] decay_inc;
   logic [10:0] half_inc;
   logic [11:0] periods_dec;
   logic [20:0] rest_dec;
   logic [4:0]  mult;
   logic [16:0] period_product;
   logic        note_ok;
   logic        rejected;

   // Table index of the playing note, out-of-range notes fall back to entry 0
   assign table_idx = ({1'b0, note_ff} < TableLimit) ? note_ff : 4'd0;
   assign out_idx   = ({1'b0, note_in} < TableLimit) ? note_in : 4'd0;

   assign interval    = (cfg.decay_interval == 16'd0) ? 16'd1 : cfg.decay_interval;
   assign decay_inc   = decay_count_ff + 16'd1;
   assign half_inc    = half_count_ff + 11'd1;
   assign periods_dec = (periods_ff != 12'd0) ? periods_ff - 12'd1 : periods_ff;
   assign rest_dec    = (rest_left_ff != 21'd0) ? rest_left_ff - 21'd1 : rest_left_ff;

   // Note length in periods: whole-note periods times sixteenths, over 16
   assign mult           = dtg_pkg::length_mult(note_length);
   assign period_product = {5'd0, dtg_pkg::whole_periods(note_index)} * {12'd0, mult};
   assign note_ok        = (mult != 5'd0) && ({1'b0, note_index} < NoteLimit)
                           && ({1'b0, note_index} < TableLimit);

   // Next state for one item
   always_comb begin
      mode_in        = mode_ff;
      volume_in      = volume_ff;
      step_in        = step_ff;
      half_count_in  = half_count_ff;
      periods_in     = periods_ff;
      phase_in       = phase_ff;
      decay_count_in = decay_count_ff;
      rest_left_in   = rest_left_ff;
      note_in        = note_ff;
      rejected       = 1'b0;

      unique case (opcode)
         dtg_pkg::OP_TICK: begin
            unique case (mode_ff)
               MODE_NOTE: begin
                  // volume decay timer, wraps to zero like a 16-bit counter
                  if (decay_inc >= interval || decay_inc == 16'd0) begin
                     decay_count_in = 16'd0;
                     volume_in      = (volume_ff > step_ff) ? volume_ff - step_ff : 8'd0;
                  end else begin
                     decay_count_in = decay_inc;
                  end
                  // square wave half periods
                  if (half_inc >= dtg_pkg::half_ticks(table_idx)) begin
                     half_count_in = 11'd0;
                     if (!phase_ff) begin
                        phase_in = 1'b1;
                     end else begin
                        phase_in   = 1'b0;
                        periods_in = periods_dec;
                        if (periods_dec == 12'd0) begin
                           mode_in = MODE_IDLE;
                        end
                     end
                  end else begin
                     half_count_in = half_inc;
                  end
               end
               MODE_REST: begin
                  rest_left_in = rest_dec;
                  if (rest_dec == 21'd0) begin
                     mode_in = MODE_IDLE;
                  end
               end
               default: begin
                  mode_in = MODE_IDLE;
               end
            endcase
         end
         dtg_pkg::OP_NOTE: begin
            if (!note_ok) begin
               rejected = 1'b1;
            end else begin
               note_in   = note_index;
               volume_in = dtg_pkg::FULL_VOLUME;
               if (note_length <= 5'd2) begin
                  step_in = cfg.slow_decay;
               end else if (note_length == 5'd3) begin
                  step_in = cfg.medium_decay;
               end else begin
                  step_in = cfg.fast_decay;
               end
               decay_count_in = 16'd0;
               half_count_in  = 11'd0;
               phase_in       = 1'b0;
               periods_in     = period_product[15:4];
               rest_left_in   = 21'd0;
               mode_in        = MODE_NOTE;
            end
         end
         dtg_pkg::OP_REST: begin
            if (mult == 5'd0) begin
               rejected = 1'b1;
            end else begin
               rest_left_in = dtg_pkg::rest_ticks(note_length);
               mode_in      = MODE_REST;
            end
         end
         default: begin
            // unused opcode: no effect
         end
      endcase
   end

   // Result seen after this item
   always_comb begin
      result.pwm_level   = (mode_in == MODE_NOTE && !phase_in) ? volume_in : 8'd0;
      result.led_pattern = (mode_in == MODE_NOTE) ? dtg_pkg::led_bits(out_idx) : 3'd0;
      result.busy_res    = (mode_in != MODE_IDLE);
      result.rejected    = rejected;
   end

   // Playback state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_IDLE;
         volume_ff      <= 8'd0;
         step_ff        <= 8'd0;
         half_count_ff  <= 11'd0;
         periods_ff     <= 12'd0;
         phase_ff       <= 1'b0;
         decay_count_ff <= 16'd0;
         rest_left_ff   <= 21'd0;
         note_ff        <= 4'd0;
      end else if (advance) begin
         mode_ff        <= mode_in;
         volume_ff      <= volume_in;
         step_ff        <= step_in;
         half_count_ff  <= half_count_in;
         periods_ff     <= periods_in;
         phase_ff       <= phase_in;
         decay_count_ff <= decay_count_in;
         rest_left_ff   <= rest_left_in;
         note_ff        <= note_in;
      end
   end

endmodule

/* hw/rtl/decaying_tone_generator.sv */
// An accepted item is held in the input register, then moved into the result register,
// from which its result is offered.
// Throughput: one item per cycle while the result register is not stalled by rsp_stall.
// The result register holds while rsp_stall is high, and the input register
// stalls behind it only when both are full.
// Reset (synchronous, active high): idle, silent, registers back to their defaults.
// ----------------------------------------------------------------------------
// Decaying tone generator
// Square-wave note player with a stepwise volume decay, driven by tick items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "decaying_tone_generator_defines.svh"

module decaying_tone_generator #(
   parameter int NOTE_COUNT = dtg_pkg::DEFAULT_NOTE_COUNT
) (
   input  logic                            clock,
   input  logic                            reset,
   // item input
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [dtg_pkg::OPCODE_W-1:0]    req_opcode,
   input  logic [dtg_pkg::NOTE_W-1:0]      req_note_index,
   input  logic [dtg_pkg::LENGTH_W-1:0]    req_note_length,
   // result output
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_pwm_level,
   output logic [2:0]                      rsp_led_pattern,
   output logic                            rsp_busy_res,
   output logic                            rsp_rejected,
   // register writes
   input  logic                            csr_write_en,
   input  logic [dtg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dtg_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   dtg_pkg::cfg_type    cfg_ff;
   dtg_pkg::result_type result_in;
   dtg_pkg::result_type result_ff;

   logic                         in_valid_ff;
   logic [dtg_pkg::OPCODE_W-1:0] opcode_ff;
   logic [dtg_pkg::NOTE_W-1:0]   note_ff;
   logic [dtg_pkg::LENGTH_W-1:0] length_ff;
   logic                         rsp_valid_ff;
   logic                         advance;
   logic                         req_take;

   // Move an item into the result register when that register is free or draining
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.decay_interval <= dtg_pkg::RESET_DECAY_INTERVAL;
         cfg_ff.slow_decay     <= dtg_pkg::RESET_SLOW_DECAY;
         cfg_ff.medium_decay   <= dtg_pkg::RESET_MEDIUM_DECAY;
         cfg_ff.fast_decay     <= dtg_pkg::RESET_FAST_DECAY;
      end else if (csr_write_en) begin
         unique case (csr_index)
            dtg_pkg::REG_DECAY_INTERVAL: cfg_ff.decay_interval <= csr_wdata;
            dtg_pkg::REG_SLOW_DECAY:     cfg_ff.slow_decay     <= csr_wdata[7:0];
            dtg_pkg::REG_MEDIUM_DECAY:   cfg_ff.medium_decay   <= csr_wdata[7:0];
            dtg_pkg::REG_FAST_DECAY:     cfg_ff.fast_decay     <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         opcode_ff <= req_opcode;
         note_ff   <= req_note_index;
         length_ff <= req_note_length;
      end
   end

   dtg_engine #(
      .NOTE_COUNT (NOTE_COUNT)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .opcode      (opcode_ff),
      .note_index  (note_ff),
      .note_length (length_ff),
      .cfg         (cfg_ff),
      .result      (result_in)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pwm_level   = result_ff.pwm_level;
   assign rsp_led_pattern = result_ff.led_pattern;
   assign rsp_busy_res    = result_ff.busy_res;
   assign rsp_rejected    = result_ff.rejected;

   // Checks
   `DTG_ASSERT_IMPLY(a_level_needs_note, clock, reset, rsp_valid && (rsp_pwm_level != 8'd0), rsp_busy_res && (rsp_led_pattern != 3'd0))
   `DTG_ASSERT_IMPLY(a_led_needs_busy, clock, reset, rsp_valid && (rsp_led_pattern != 3'd0), rsp_busy_res)
   `DTG_ASSERT_IMPLY(a_stall_only_when_full, clock, reset, req_stall, in_valid_ff && rsp_valid_ff && rsp_stall)
   `DTG_ASSERT_NEXT(a_advance_fills_result, clock, reset, advance, rsp_valid_ff)

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decaying tone generator testbench
// Drives tick, note and rest commands through the request channel under random
// idle and stall bursts. A tone tracker mirrors the player state and checks
// every result in order. Register settings change between phases. A final
// phase runs back to back with no idling on either side.
// ----------------------------------------------------------------------------

module tb;

   localparam int CYCLE_LIMIT = 2_000_000;

   // Opcode with no function, the block must ignore it
   localparam logic [dtg_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

   // Length codes
   localparam logic [dtg_pkg::LENGTH_W-1:0] LEN_WHOLE       = 5'd1;
   localparam logic [dtg_pkg::LENGTH_W-1:0] LEN_HALF        = 5'd2;
   localparam logic [dtg_pkg::LENGTH_W-1:0] LEN_DOT_QUARTER = 5'd3;
   localparam logic [dtg_pkg::LENGTH_W-1:0] LEN_QUARTER     = 5'd4;
   localparam logic [dtg_pkg::LENGTH_W-1:0] LEN_DOT_EIGHTH  = 5'd6;
   localparam logic [dtg_pkg::LENGTH_W-1:0] LEN_EIGHTH      = 5'd8;
   localparam logic [dtg_pkg::LENGTH_W-1:0] LEN_SIXTEENTH   = 5'd16;

   typedef enum logic [1:0] {MODE_IDLE, MODE_NOTE, MODE_REST} play_mode_type;

   // Tracks the player state and queues the result each command should give
   class tone_tracker;
      logic [15:0] decay_interval;
      logic [7:0]  slow_decay, medium_decay, fast_decay;
      logic [7:0]  volume, decay_step;
      logic [10:0] half_count;
      logic [11:0] periods_left;
      logic        wave_phase;
      logic [15:0] decay_count;
      logic [20:0] rest_left;
      play_mode_type mode;
      logic [3:0]  cur_note;
      dtg_pkg::result_type expected_q[$];
      int          errors;

      function new();
         errors = 0;
         reset_state();
      endfunction

      function void reset_state();
         decay_interval = dtg_pkg::RESET_DECAY_INTERVAL;
         slow_decay     = dtg_pkg::RESET_SLOW_DECAY;
         medium_decay   = dtg_pkg::RESET_MEDIUM_DECAY;
         fast_decay     = dtg_pkg::RESET_FAST_DECAY;
         volume = '0; decay_step = '0; half_count = '0; periods_left = '0;
         wave_phase = 1'b0; decay_count = '0; rest_left = '0;
         mode = MODE_IDLE; cur_note = '0;
      endfunction

      function void set_reg(logic [dtg_pkg::CSR_INDEX_W-1:0] idx,
                            logic [dtg_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            dtg_pkg::REG_DECAY_INTERVAL: decay_interval = data;
            dtg_pkg::REG_SLOW_DECAY:     slow_decay     = data[7:0];
            dtg_pkg::REG_MEDIUM_DECAY:   medium_decay   = data[7:0];
            default:                     fast_decay     = data[7:0];
         endcase
      endfunction

      // Tone tables, G4 up to E6
      function int unsigned half_period_of(logic [3:0] n);
         case (n)
            1: return 1132;  2: return 1012;  3: return 950;  4: return 851;
            5: return 758;   6: return 715;   7: return 633;  8: return 568;
            9: return 506;  10: return 473;  11: return 422; 12: return 379;
            default: return 1270;
         endcase
      endfunction

      function int unsigned periods_per_whole(logic [3:0] n);
         case (n)
            1: return 880;   2: return 976;   3: return 1040;  4: return 1168;
            5: return 1312;  6: return 1392;  7: return 1568;  8: return 1760;
            9: return 1968; 10: return 2080; 11: return 2336; 12: return 2624;
            default: return 784;
         endcase
      endfunction

      function logic [2:0] leds_of(logic [3:0] n);
         case (n)
            1, 8:  return 3'd5;
            2, 9:  return 3'd7;
            3, 10: return 3'd1;
            4, 11: return 3'd2;
            5, 12: return 3'd4;
            6:     return 3'd3;
            default: return 3'd6;
         endcase
      endfunction

      // Sixteenths of a whole note, 0 for a bad code
      function int unsigned sixteenths_of(logic [dtg_pkg::LENGTH_W-1:0] code);
         case (code)
            LEN_WHOLE:       return 16;
            LEN_HALF:        return 8;
            LEN_DOT_QUARTER: return 6;
            LEN_QUARTER:     return 4;
            LEN_DOT_EIGHTH:  return 3;
            LEN_EIGHTH:      return 2;
            LEN_SIXTEENTH:   return 1;
            default:         return 0;
         endcase
      endfunction

      function bit busy();
         return mode != MODE_IDLE;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // One microsecond of playing
      function void advance();
         logic [15:0] interval;
         if (mode == MODE_NOTE) begin
            interval = (decay_interval == 16'd0) ? 16'd1 : decay_interval;
            decay_count = decay_count + 16'd1;
            if (decay_count >= interval || decay_count == 16'd0) begin
               decay_count = '0;
               volume = (volume > decay_step) ? volume - decay_step : 8'd0;
            end
            half_count = half_count + 11'd1;
            if (half_count >= half_period_of(cur_note)) begin
               half_count = '0;
               if (!wave_phase) begin
                  wave_phase = 1'b1;
               end else begin
                  wave_phase = 1'b0;
                  if (periods_left > 12'd0) periods_left = periods_left - 12'd1;
                  if (periods_left == 12'd0) mode = MODE_IDLE;
               end
            end
         end else if (mode == MODE_REST) begin
            if (rest_left > 21'd0) rest_left = rest_left - 21'd1;
            if (rest_left == 21'd0) mode = MODE_IDLE;
         end
      endfunction

      // Accepted command: update state, queue the expected result
      function void accept_cmd(logic [dtg_pkg::OPCODE_W-1:0] op,
                               logic [dtg_pkg::NOTE_W-1:0] n,
                               logic [dtg_pkg::LENGTH_W-1:0] len);
         int unsigned mult;
         int unsigned span;
         bit          rej;
         dtg_pkg::result_type want;
         mult = sixteenths_of(len);
         rej  = 0;
         case (op)
            dtg_pkg::OP_TICK: advance();
            dtg_pkg::OP_NOTE: begin
               if (mult == 0 || n >= dtg_pkg::DEFAULT_NOTE_COUNT ||
                   n >= dtg_pkg::TABLE_NOTES) begin
                  rej = 1;
               end else begin
                  cur_note     = n;
                  volume       = dtg_pkg::FULL_VOLUME;
                  decay_step   = (len <= LEN_HALF) ? slow_decay :
                                 (len == LEN_DOT_QUARTER) ? medium_decay : fast_decay;
                  decay_count  = '0;
                  half_count   = '0;
                  wave_phase   = 1'b0;
                  span         = periods_per_whole(n) * mult / 16;
                  periods_left = span[11:0];
                  rest_left    = '0;
                  mode         = MODE_NOTE;
               end
            end
            dtg_pkg::OP_REST: begin
               if (mult == 0) begin
                  rej = 1;
               end else begin
                  span      = 125000 * mult;
                  rest_left = span[20:0];
                  mode      = MODE_REST;
               end
            end
            default: ;
         endcase
         want.pwm_level   = (mode == MODE_NOTE && !wave_phase) ? volume : 8'd0;
         want.led_pattern = (mode == MODE_NOTE) ? leds_of(cur_note) : 3'd0;
         want.busy_res    = (mode != MODE_IDLE);
         want.rejected    = rej;
         expected_q.push_back(want);
      endfunction

      function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
         if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v,
                     act_v);
            errors++;
         end
      endfunction

      // Result seen on the output channel
      function void check_output(dtg_pkg::result_type got);
         dtg_pkg::result_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if ($isunknown(got)) begin
            $display("%0t: unknown bits, expected %h, actual %h", $time, want, got);
            errors++;
            return;
         end
         compare_field("pwm_level", want.pwm_level, got.pwm_level);
         compare_field("led_pattern", want.led_pattern, got.led_pattern);
         compare_field("busy_res", want.busy_res, got.busy_res);
         compare_field("rejected", want.rejected, got.rejected);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [dtg_pkg::OPCODE_W-1:0] req_opcode = dtg_pkg::OP_TICK;
   logic [dtg_pkg::NOTE_W-1:0]   req_note_index = '0;
   logic [dtg_pkg::LENGTH_W-1:0] req_note_length = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [7:0] rsp_pwm_level;
   logic [2:0] rsp_led_pattern;
   logic rsp_busy_res;
   logic rsp_rejected;
   logic csr_write_en = 1'b0;
   logic [dtg_pkg::CSR_INDEX_W-1:0] csr_index = dtg_pkg::REG_DECAY_INTERVAL;
   logic [dtg_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   tone_tracker tracker;
   bit          gaps_on = 0;
   bit          stalls_on = 0;
   int          stall_left = 0;
   int          cycles = 0;
   dtg_pkg::result_type got;

   decaying_tone_generator dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_note_index  (req_note_index),
      .req_note_length (req_note_length),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pwm_level   (rsp_pwm_level),
      .rsp_led_pattern (rsp_led_pattern),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_rejected    (rsp_rejected),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #4 clock = ~clock;

   // Watchdog, result checking and output stall bursts
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got.pwm_level   = rsp_pwm_level;
         got.led_pattern = rsp_led_pattern;
         got.busy_res    = rsp_busy_res;
         got.rejected    = rsp_rejected;
         tracker.check_output(got);
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
         stall_left = int'($urandom_range(1, 17)) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Send one command item, with an occasional idle burst in front
   task automatic issue_cmd(input logic [dtg_pkg::OPCODE_W-1:0] op,
                            input logic [dtg_pkg::NOTE_W-1:0] n,
                            input logic [dtg_pkg::LENGTH_W-1:0] len);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_note_index  <= n;
      req_note_length <= len;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.accept_cmd(op, n, len);
   endtask

   task automatic send_tick();
      issue_cmd(dtg_pkg::OP_TICK, 4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)));
   endtask

   // Stop sending and wait for every outstanding result
   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write all four registers, block idle
   task automatic program_regs(input logic [15:0] interval, input logic [7:0] slow,
                               input logic [7:0] med, input logic [7:0] fast);
      logic [dtg_pkg::CSR_INDEX_W-1:0] idx [4];
      logic [dtg_pkg::CSR_DATA_W-1:0]  val [4];
      idx[0] = dtg_pkg::REG_DECAY_INTERVAL; val[0] = interval;
      idx[1] = dtg_pkg::REG_SLOW_DECAY;     val[1] = {8'd0, slow};
      idx[2] = dtg_pkg::REG_MEDIUM_DECAY;   val[2] = {8'd0, med};
      idx[3] = dtg_pkg::REG_FAST_DECAY;     val[3] = {8'd0, fast};
      for (int i = 0; i < 4; i++) begin
         csr_write_en <= 1'b1;
         csr_index    <= idx[i];
         csr_wdata    <= val[i];
         @(posedge clock);
         tracker.set_reg(idx[i], val[i]);
      end
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly note/rest commands followed by tick runs; some raw noise
   task automatic play_random(input int budget);
      int sent;
      int run;
      logic [dtg_pkg::OPCODE_W-1:0] op;
      logic [dtg_pkg::LENGTH_W-1:0] len;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(0, 99) < 15) begin
            op = 2'($urandom_range(0, 3));
            issue_cmd(op, 4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)));
            sent++;
         end else begin
            case ($urandom_range(0, 6))
               0: len = LEN_WHOLE;
               1: len = LEN_HALF;
               2: len = LEN_DOT_QUARTER;
               3: len = LEN_QUARTER;
               4: len = LEN_DOT_EIGHTH;
               5: len = LEN_EIGHTH;
               default: len = LEN_SIXTEENTH;
            endcase
            if ($urandom_range(0, 3) == 0)
               issue_cmd(dtg_pkg::OP_REST, 4'($urandom_range(0, 15)), len);
            else
               issue_cmd(dtg_pkg::OP_NOTE, 4'($urandom_range(0, 12)), len);
            sent++;
            run = ($urandom_range(0, 49) == 0) ? int'($urandom_range(380, 800))
                                               : int'($urandom_range(0, 30));
            // keep the phase within its item budget
            if (run > budget - sent) run = budget - sent;
            repeat (run) send_tick();
            sent += run;
         end
      end
   endtask

   initial begin
      tracker = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: rejections, every length code, replacement while playing
      issue_cmd(dtg_pkg::OP_TICK, 4'd0, 5'd0);
      issue_cmd(OP_UNUSED, 4'd15, 5'd31);
      issue_cmd(dtg_pkg::OP_NOTE, 4'd0, 5'd0);
      issue_cmd(dtg_pkg::OP_NOTE, 4'd0, 5'd5);
      issue_cmd(dtg_pkg::OP_NOTE, 4'd13, LEN_WHOLE);
      issue_cmd(dtg_pkg::OP_NOTE, 4'd15, 5'd31);
      issue_cmd(dtg_pkg::OP_NOTE, 4'd0, LEN_WHOLE);
      issue_cmd(dtg_pkg::OP_TICK, 4'd15, 5'd31);
      issue_cmd(dtg_pkg::OP_TICK, 4'd0, 5'd0);
      issue_cmd(dtg_pkg::OP_NOTE, 4'd12, LEN_SIXTEENTH);
      issue_cmd(dtg_pkg::OP_TICK, 4'd0, 5'd0);
      issue_cmd(dtg_pkg::OP_NOTE, 4'd5, LEN_DOT_QUARTER);
      issue_cmd(dtg_pkg::OP_NOTE, 4'd3, LEN_HALF);
      issue_cmd(dtg_pkg::OP_NOTE, 4'd7, LEN_QUARTER);
      issue_cmd(dtg_pkg::OP_NOTE, 4'd9, LEN_DOT_EIGHTH);
      issue_cmd(dtg_pkg::OP_NOTE, 4'd11, LEN_EIGHTH);
      issue_cmd(dtg_pkg::OP_REST, 4'd0, 5'd7);
      issue_cmd(dtg_pkg::OP_REST, 4'd0, LEN_SIXTEENTH);
      issue_cmd(dtg_pkg::OP_TICK, 4'd0, 5'd0);
      issue_cmd(dtg_pkg::OP_REST, 4'd15, LEN_WHOLE);
      issue_cmd(dtg_pkg::OP_NOTE, 4'd1, LEN_SIXTEENTH);
      issue_cmd(dtg_pkg::OP_NOTE, 4'd10, 5'd0);
      issue_cmd(dtg_pkg::OP_TICK, 4'd0, 5'd0);
      issue_cmd(dtg_pkg::OP_REST, 4'd0, LEN_DOT_QUARTER);
      issue_cmd(dtg_pkg::OP_TICK, 4'd0, 5'd0);
      drain();

      // Random phases under several register settings, extremes included
      gaps_on   = 1;
      stalls_on = 1;
      program_regs(16'd0, 8'd255, 8'd0, 8'd1);
      play_random(165);
      drain();
      program_regs(16'd65535, 8'd0, 8'd255, 8'd128);
      play_random(165);
      drain();
      program_regs(16'd1, 8'd1, 8'd2, 8'd3);
      play_random(165);
      drain();
      program_regs(16'($urandom_range(1, 60)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      play_random(165);
      drain();

      // Back to back: fast decay down to silence, a rest, then a new note
      gaps_on   = 0;
      stalls_on = 0;
      program_regs(16'd3, 8'd5, 8'd7, 8'd255);
      issue_cmd(dtg_pkg::OP_NOTE, 4'd12, LEN_SIXTEENTH);
      repeat (20) send_tick();
      issue_cmd(dtg_pkg::OP_REST, 4'd3, LEN_SIXTEENTH);
      repeat (10) send_tick();
      issue_cmd(dtg_pkg::OP_NOTE, 4'd2, LEN_QUARTER);
      repeat (20) send_tick();
      drain();
      repeat (8) @(posedge clock);

      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
